FILE: hdl/pwrf_pkg.sv
// ----------------------------------------------------------------------------
// pwrf_pkg
// Shared constants, register indexes and the CRC-16 byte update for the
// pulse-width RF frame transmitter.
// ----------------------------------------------------------------------------
package pwrf_pkg;

  localparam int COUNT_WIDTH_DEFAULT = 12;
  localparam int CFG_WIDTH           = 12;
  localparam int CFG_INDEX_WIDTH     = 3;
  localparam int LEN_WIDTH           = 12;
  localparam int RING_WIDTH          = 8;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_ZERO_HIGH = 3'd0,
    REG_ONE_HIGH  = 3'd1,
    REG_BIT_GAP   = 3'd2,
    REG_RING_HALF = 3'd3,
    REG_RING_CYC  = 3'd4,
    REG_RING_TAIL = 3'd5
  } cfg_reg_t;

  localparam logic [LEN_WIDTH-1:0]  ZERO_HIGH_RESET = 12'd900;
  localparam logic [LEN_WIDTH-1:0]  ONE_HIGH_RESET  = 12'd450;
  localparam logic [LEN_WIDTH-1:0]  BIT_GAP_RESET   = 12'd200;
  localparam logic [LEN_WIDTH-1:0]  RING_HALF_RESET = 12'd200;
  localparam logic [RING_WIDTH-1:0] RING_CYC_RESET  = 8'd100;
  localparam logic [LEN_WIDTH-1:0]  RING_TAIL_RESET = 12'd1000;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // reflected CRC-16, one byte
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: hdl/pwrf_in_if.sv
// ----------------------------------------------------------------------------
// pwrf_in_if
// Tick request channel: one tick with an optional message byte.
// ----------------------------------------------------------------------------
interface pwrf_in_if;
  logic       valid;
  logic       ready;
  logic       byte_offered;
  logic [7:0] byte_value;
  logic       byte_is_last;

  modport source (output valid, byte_offered, byte_value, byte_is_last, input ready);
  modport sink   (input valid, byte_offered, byte_value, byte_is_last, output ready);
endinterface

FILE: hdl/pwrf_out_if.sv
// ----------------------------------------------------------------------------
// pwrf_out_if
// Tick result channel: line level and frame status for one tick.
// ----------------------------------------------------------------------------
interface pwrf_out_if;
  logic valid;
  logic ready;
  logic line_level;
  logic byte_taken;
  logic frame_done;
  logic busy_res;

  modport source (output valid, line_level, byte_taken, frame_done, busy_res, input ready);
  modport sink   (input valid, line_level, byte_taken, frame_done, busy_res, output ready);
endinterface

FILE: hdl/pulse_width_rf_frame_transmitter_top.sv
// ----------------------------------------------------------------------------
// pulse_width_rf_frame_transmitter_top
// Pulse-width OOK frame transmitter with preamble and CRC-16/MODBUS trailer.
// ----------------------------------------------------------------------------
// One tick request is taken per clock cycle and yields its result in the next
// cycle through a single result register; the whole tick update (segment
// counters, bit shifter, CRC-16 byte fold) is done in one pass between the
// state registers and that register. Requests stall only while the result
// register is full and not being taken. Lengths of 0 act as 1 tick, and
// lengths above 2^COUNT_WIDTH-1 are clamped to it.
module pulse_width_rf_frame_transmitter_top
  import pwrf_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0]       cfg_data,
  pwrf_in_if.sink                    tick_in,
  pwrf_out_if.source                 tick_out
);

  localparam int CMP_WIDTH = 17;
  localparam logic [CMP_WIDTH-1:0] CNT_MAX = (CMP_WIDTH'(1) << COUNT_WIDTH) - CMP_WIDTH'(1);

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_RING_LOW  = 3'd1,
    PH_RING_HIGH = 3'd2,
    PH_TAIL      = 3'd3,
    PH_SLOT      = 3'd4,
    PH_BIT_HIGH  = 3'd5,
    PH_BIT_GAP   = 3'd6
  } phase_t;

  typedef struct packed {
    logic line_level;
    logic byte_taken;
    logic frame_done;
    logic busy_res;
  } result_t;

  logic [LEN_WIDTH-1:0]  zero_high_ticks, one_high_ticks, bit_gap_ticks;
  logic [LEN_WIDTH-1:0]  ring_half_ticks, ring_tail_ticks;
  logic [RING_WIDTH-1:0] ring_cycles;

  phase_t                 phase, phase_next;
  logic [COUNT_WIDTH-1:0] tick_count, tick_count_next;
  logic [RING_WIDTH-1:0]  ring_count, ring_count_next;
  logic [2:0]             bit_index, bit_index_next;
  logic [7:0]             shift_byte, shift_byte_next;
  logic [15:0]            crc_value, crc_value_next;
  logic                   last_seen, last_seen_next;
  logic [1:0]             trailer_index, trailer_index_next;

  logic    out_valid;
  result_t res, res_next;
  logic    accept;

  assign tick_in.ready = !out_valid || tick_out.ready;
  assign accept        = tick_in.valid && tick_in.ready;

  assign tick_out.valid      = out_valid;
  assign tick_out.line_level = res.line_level;
  assign tick_out.byte_taken = res.byte_taken;
  assign tick_out.frame_done = res.frame_done;
  assign tick_out.busy_res   = res.busy_res;

  // test the next step of a segment counter; true when the segment ends
  function automatic logic seg_end(input logic [COUNT_WIDTH-1:0] tc,
                                   input logic [LEN_WIDTH-1:0] len);
    logic [CMP_WIDTH-1:0] l;
    logic [CMP_WIDTH-1:0] t;
    l = CMP_WIDTH'(len);
    if (l == '0) l = CMP_WIDTH'(1);
    if (l > CNT_MAX) l = CNT_MAX;
    t = CMP_WIDTH'(COUNT_WIDTH'(tc + COUNT_WIDTH'(1)));
    return t >= l;
  endfunction

  always_comb begin
    logic [RING_WIDTH-1:0] cycles;
    logic [RING_WIDTH-1:0] rc_inc;
    logic [LEN_WIDTH-1:0]  hi_len;
    logic                  fin;
    phase_next         = phase;
    tick_count_next    = tick_count;
    ring_count_next    = ring_count;
    bit_index_next     = bit_index;
    shift_byte_next    = shift_byte;
    crc_value_next     = crc_value;
    last_seen_next     = last_seen;
    trailer_index_next = trailer_index;
    res_next           = '{line_level: 1'b0, byte_taken: 1'b0, frame_done: 1'b0,
                           busy_res: 1'b1};
    cycles = (ring_cycles == '0) ? RING_WIDTH'(1) : ring_cycles;
    rc_inc = ring_count + RING_WIDTH'(1);
    hi_len = '0;
    fin    = 1'b0;

    if (phase == PH_IDLE) begin
      if (tick_in.byte_offered) begin
        crc_value_next     = CRC_INIT;
        ring_count_next    = '0;
        tick_count_next    = '0;
        bit_index_next     = '0;
        last_seen_next     = 1'b0;
        trailer_index_next = '0;
        phase_next         = PH_RING_LOW;
      end else begin
        res_next.busy_res = 1'b0;
      end
    end

    case (phase_next)
      PH_IDLE: begin
        res_next.busy_res = 1'b0;
      end
      PH_RING_LOW: begin
        fin = seg_end(tick_count_next, ring_half_ticks);
        tick_count_next = fin ? '0 : tick_count_next + COUNT_WIDTH'(1);
        if (fin) phase_next = PH_RING_HIGH;
      end
      PH_RING_HIGH: begin
        res_next.line_level = 1'b1;
        fin = seg_end(tick_count_next, ring_half_ticks);
        tick_count_next = fin ? '0 : tick_count_next + COUNT_WIDTH'(1);
        if (fin) begin
          ring_count_next = rc_inc;
          phase_next = (rc_inc >= cycles) ? PH_TAIL : PH_RING_LOW;
        end
      end
      PH_TAIL: begin
        fin = seg_end(tick_count_next, ring_tail_ticks);
        tick_count_next = fin ? '0 : tick_count_next + COUNT_WIDTH'(1);
        if (fin) phase_next = PH_SLOT;
      end
      PH_SLOT: begin
        if (tick_in.byte_offered) begin
          res_next.byte_taken = 1'b1;
          res_next.line_level = 1'b1;
          crc_value_next  = crc_fold(crc_value_next, tick_in.byte_value);
          shift_byte_next = tick_in.byte_value;
          last_seen_next  = tick_in.byte_is_last;
          bit_index_next  = '0;
          hi_len = tick_in.byte_value[7] ? one_high_ticks : zero_high_ticks;
          fin = seg_end('0, hi_len);
          tick_count_next = fin ? '0 : COUNT_WIDTH'(1);
          phase_next = fin ? PH_BIT_GAP : PH_BIT_HIGH;
        end
      end
      PH_BIT_HIGH: begin
        res_next.line_level = 1'b1;
        hi_len = shift_byte_next[7] ? one_high_ticks : zero_high_ticks;
        fin = seg_end(tick_count_next, hi_len);
        tick_count_next = fin ? '0 : tick_count_next + COUNT_WIDTH'(1);
        if (fin) phase_next = PH_BIT_GAP;
      end
      PH_BIT_GAP: begin
        fin = seg_end(tick_count_next, bit_gap_ticks);
        tick_count_next = fin ? '0 : tick_count_next + COUNT_WIDTH'(1);
        if (fin) begin
          shift_byte_next = {shift_byte_next[6:0], 1'b0};
          bit_index_next  = bit_index_next + 3'd1;
          phase_next      = PH_BIT_HIGH;
          if (bit_index_next == 3'd0) begin
            if (trailer_index_next == 2'd0) begin
              if (last_seen_next) begin
                trailer_index_next = 2'd1;
                shift_byte_next    = crc_value_next[7:0];
              end else begin
                phase_next = PH_SLOT;
              end
            end else if (trailer_index_next == 2'd1) begin
              trailer_index_next = 2'd2;
              shift_byte_next    = crc_value_next[15:8];
            end else begin
              res_next.frame_done = 1'b1;
              trailer_index_next  = 2'd0;
              last_seen_next      = 1'b0;
              ring_count_next     = '0;
              phase_next          = PH_IDLE;
            end
          end
        end
      end
      default: begin
        phase_next = PH_IDLE;
        res_next.busy_res = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_high_ticks <= ZERO_HIGH_RESET;
      one_high_ticks  <= ONE_HIGH_RESET;
      bit_gap_ticks   <= BIT_GAP_RESET;
      ring_half_ticks <= RING_HALF_RESET;
      ring_cycles     <= RING_CYC_RESET;
      ring_tail_ticks <= RING_TAIL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ZERO_HIGH: zero_high_ticks <= cfg_data[LEN_WIDTH-1:0];
        REG_ONE_HIGH:  one_high_ticks  <= cfg_data[LEN_WIDTH-1:0];
        REG_BIT_GAP:   bit_gap_ticks   <= cfg_data[LEN_WIDTH-1:0];
        REG_RING_HALF: ring_half_ticks <= cfg_data[LEN_WIDTH-1:0];
        REG_RING_CYC:  ring_cycles     <= cfg_data[RING_WIDTH-1:0];
        REG_RING_TAIL: ring_tail_ticks <= cfg_data[LEN_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      tick_count    <= '0;
      ring_count    <= '0;
      bit_index     <= '0;
      shift_byte    <= '0;
      crc_value     <= CRC_INIT;
      last_seen     <= 1'b0;
      trailer_index <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (accept) begin
        phase         <= phase_next;
        tick_count    <= tick_count_next;
        ring_count    <= ring_count_next;
        bit_index     <= bit_index_next;
        shift_byte    <= shift_byte_next;
        crc_value     <= crc_value_next;
        last_seen     <= last_seen_next;
        trailer_index <= trailer_index_next;
        out_valid     <= 1'b1;
      end else if (tick_out.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (accept) begin
      res <= res_next;
    end
  end

endmodule

FILE: verif/pulse_width_rf_frame_transmitter_top_tb.sv
// ----------------------------------------------------------------------------
// pulse_width_rf_frame_transmitter_top_tb
// Drives tick requests into the pulse-width RF frame transmitter and checks
// every tick result (line level, byte taken, frame done, busy) against an
// in-bench model of the transmitter.
// Covers frame starts on reset and maximum timing, minimum, zero and random
// small timing settings, a 255-period preamble, stalls in slots and ignored
// offers. Both channels idle at random.
// ----------------------------------------------------------------------------
module pulse_width_rf_frame_transmitter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pwrf_pkg::*;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE = 3'd7;
  localparam int WIND_CHUNK = 16;

  typedef enum logic [2:0] {
    TX_IDLE, TX_RING_LOW, TX_RING_HIGH, TX_TAIL, TX_SLOT, TX_BIT_HIGH, TX_BIT_GAP
  } tx_phase_e;

  typedef enum logic [1:0] {RX_OPEN, RX_ALT, RX_3OF4, RX_RAND} rx_mode_e;

  typedef struct packed {
    logic       offered;
    logic [7:0] value;
    logic       last;
  } tick_req_t;

  typedef struct packed {
    logic level;
    logic taken;
    logic done;
    logic busy;
  } line_tick_t;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       cfg_we;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [CFG_WIDTH-1:0]       cfg_data;

  pwrf_in_if  tick_req_bus ();
  pwrf_out_if line_bus ();

  pulse_width_rf_frame_transmitter_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tick_in   (tick_req_bus),
    .tick_out  (line_bus)
  );

  // model timing registers
  logic [LEN_WIDTH-1:0]  len_zero, len_one, len_gap, len_half, len_tail;
  logic [RING_WIDTH-1:0] ring_target;

  // model state
  tx_phase_e             ph;
  logic [LEN_WIDTH-1:0]  tick_cnt;
  logic [RING_WIDTH-1:0] ring_cnt;
  logic [2:0]            bit_idx;
  logic [7:0]            shreg;
  logic [15:0]           crc_acc;
  logic                  last_flag;
  logic [1:0]            trailer_idx;

  tick_req_t  tick_requests[$];
  line_tick_t line_ticks_due[$];
  tick_req_t  next_req;
  line_tick_t want_tick;

  int          errors = 0;
  int          ticks_seen = 0;
  int          bytes_taken = 0;
  int          frames_done = 0;
  int          settings = 1;
  logic        in_taken = 1'b0;
  int          gap_left = 0;
  int          burst_left = 0;
  int unsigned rx_cnt = 0;
  rx_mode_e    rx_mode = RX_OPEN;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // reflected CRC-16, bit-serial form
  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = c;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ b[i];
      r  = r >> 1;
      if (fb) r = r ^ CRC_POLY;
    end
    return r;
  endfunction

  function automatic void reset_model();
    len_zero    = ZERO_HIGH_RESET;
    len_one     = ONE_HIGH_RESET;
    len_gap     = BIT_GAP_RESET;
    len_half    = RING_HALF_RESET;
    ring_target = RING_CYC_RESET;
    len_tail    = RING_TAIL_RESET;
    ph          = TX_IDLE;
    tick_cnt    = '0;
    ring_cnt    = '0;
    bit_idx     = '0;
    shreg       = '0;
    crc_acc     = CRC_INIT;
    last_flag   = 1'b0;
    trailer_idx = '0;
  endfunction

  function automatic logic count_step(input logic [LEN_WIDTH-1:0] len);
    logic [LEN_WIDTH-1:0] lim;
    lim = (len == '0) ? LEN_WIDTH'(1) : len;
    tick_cnt = tick_cnt + 1'b1;
    if (tick_cnt >= lim) begin
      tick_cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void bit_high_step();
    if (count_step(shreg[7] ? len_one : len_zero)) ph = TX_BIT_GAP;
  endfunction

  function automatic line_tick_t compute_line_tick(input tick_req_t rq);
    line_tick_t r;
    r = '{level: 1'b0, taken: 1'b0, done: 1'b0, busy: 1'b1};
    if (ph == TX_IDLE) begin
      if (rq.offered) begin
        crc_acc     = CRC_INIT;
        ring_cnt    = '0;
        tick_cnt    = '0;
        bit_idx     = '0;
        last_flag   = 1'b0;
        trailer_idx = '0;
        ph          = TX_RING_LOW;
      end else begin
        r.busy = 1'b0;
      end
    end
    case (ph)
      TX_RING_LOW: begin
        if (count_step(len_half)) ph = TX_RING_HIGH;
      end
      TX_RING_HIGH: begin
        r.level = 1'b1;
        if (count_step(len_half)) begin
          ring_cnt = ring_cnt + 1'b1;
          ph = (ring_cnt >= ((ring_target == '0) ? RING_WIDTH'(1) : ring_target)) ?
               TX_TAIL : TX_RING_LOW;
        end
      end
      TX_TAIL: begin
        if (count_step(len_tail)) ph = TX_SLOT;
      end
      TX_SLOT: begin
        if (rq.offered) begin
          r.taken   = 1'b1;
          r.level   = 1'b1;
          crc_acc   = crc_byte(crc_acc, rq.value);
          shreg     = rq.value;
          last_flag = rq.last;
          bit_idx   = '0;
          tick_cnt  = '0;
          ph        = TX_BIT_HIGH;
          bit_high_step();
        end
      end
      TX_BIT_HIGH: begin
        r.level = 1'b1;
        bit_high_step();
      end
      TX_BIT_GAP: begin
        if (count_step(len_gap)) begin
          shreg   = shreg << 1;
          bit_idx = bit_idx + 1'b1;
          ph      = TX_BIT_HIGH;
          if (bit_idx == 3'd0) begin
            if (trailer_idx == 2'd0) begin
              if (last_flag) begin
                trailer_idx = 2'd1;
                shreg       = crc_acc[7:0];
              end else begin
                ph = TX_SLOT;
              end
            end else if (trailer_idx == 2'd1) begin
              trailer_idx = 2'd2;
              shreg       = crc_acc[15:8];
            end else begin
              r.done      = 1'b1;
              trailer_idx = '0;
              last_flag   = 1'b0;
              ring_cnt    = '0;
              ph          = TX_IDLE;
            end
          end
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic check_field(input string fname, input logic want, input logic got);
    if (got !== want) begin
      errors++;
      $display("%0t: tick %0d %s mismatch, expected %b, got %b",
               $time, ticks_seen, fname, want, got);
    end
  endtask

  // request acceptance, prediction and result checking
  always @(posedge clk) begin
    if (rst) begin
      in_taken = 1'b0;
    end else begin
      in_taken = (tick_req_bus.valid === 1'b1) && (tick_req_bus.ready === 1'b1);
      if (in_taken) begin
        line_ticks_due.push_back(compute_line_tick('{offered: tick_req_bus.byte_offered,
                                                     value:   tick_req_bus.byte_value,
                                                     last:    tick_req_bus.byte_is_last}));
      end
      if ((line_bus.valid === 1'b1) && (line_bus.ready === 1'b1)) begin
        ticks_seen++;
        if (line_bus.byte_taken === 1'b1) bytes_taken++;
        if (line_bus.frame_done === 1'b1) frames_done++;
        if (line_ticks_due.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected, expected none, got %b%b%b%b",
                   $time, line_bus.line_level, line_bus.byte_taken,
                   line_bus.frame_done, line_bus.busy_res);
        end else begin
          want_tick = line_ticks_due.pop_front();
          check_field("line_level", want_tick.level, line_bus.line_level);
          check_field("byte_taken", want_tick.taken, line_bus.byte_taken);
          check_field("frame_done", want_tick.done, line_bus.frame_done);
          check_field("busy_res", want_tick.busy, line_bus.busy_res);
        end
      end
    end
  end

  // request driver: bursts with random gaps
  always @(negedge clk) begin
    if (rst) begin
      tick_req_bus.valid <= 1'b0;
    end else if (!tick_req_bus.valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        tick_req_bus.valid <= 1'b0;
      end else if (tick_requests.size() > 0) begin
        next_req = tick_requests.pop_front();
        tick_req_bus.valid        <= 1'b1;
        tick_req_bus.byte_offered <= next_req.offered;
        tick_req_bus.byte_value   <= next_req.value;
        tick_req_bus.byte_is_last <= next_req.last;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 3);
        end
      end else begin
        tick_req_bus.valid <= 1'b0;
      end
    end
  end

  // result receiver: open, alternating, three-of-four or random stall pattern, chosen at random
  always @(negedge clk) begin
    if (rst) begin
      line_bus.ready <= 1'b0;
    end else begin
      rx_cnt++;
      if (rx_cnt[7:0] == 8'd0) rx_mode = rx_mode_e'($urandom_range(0, 3));
      case (rx_mode)
        RX_OPEN: line_bus.ready <= 1'b1;
        RX_ALT:  line_bus.ready <= rx_cnt[0];
        RX_3OF4: line_bus.ready <= (rx_cnt[1:0] != 2'd0);
        default: line_bus.ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_tick(input logic off, input logic [7:0] v, input logic l);
    tick_requests.push_back('{offered: off, value: v, last: l});
  endtask

  task automatic wait_drained();
    while (tick_requests.size() != 0 || tick_req_bus.valid === 1'b1 ||
           line_ticks_due.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [CFG_WIDTH-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_ZERO_HIGH: len_zero    = val;
      REG_ONE_HIGH:  len_one     = val;
      REG_BIT_GAP:   len_gap     = val;
      REG_RING_HALF: len_half    = val;
      REG_RING_CYC:  ring_target = val[RING_WIDTH-1:0];
      REG_RING_TAIL: len_tail    = val;
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_timing(input logic [CFG_WIDTH-1:0] zero_len, one_len, gap_len,
                            half_len, cycles, tail_len);
    write_reg(REG_ZERO_HIGH, zero_len);
    write_reg(REG_ONE_HIGH, one_len);
    write_reg(REG_BIT_GAP, gap_len);
    write_reg(REG_RING_HALF, half_len);
    write_reg(REG_RING_CYC, cycles);
    write_reg(REG_RING_TAIL, tail_len);
    settings++;
  endtask

  // let the frame in flight run out: silent ticks, a last byte in each open slot
  task automatic finish_frame();
    wait_drained();
    while (ph != TX_IDLE) begin
      if (ph == TX_SLOT) begin
        push_tick(1'b1, rand_byte(), 1'b1);
      end else begin
        repeat (WIND_CHUNK) push_tick(1'b0, rand_byte(), 1'($urandom_range(0, 1)));
      end
      wait_drained();
    end
  endtask

  task automatic run_random(input int n, input int density);
    repeat (n) begin
      push_tick(1'($urandom_range(0, 99) < density), rand_byte(),
                1'($urandom_range(0, 99) < 20));
    end
    finish_frame();
  endtask

  initial begin
    int dens;
    rst                       = 1'b1;
    cfg_we                    = 1'b0;
    cfg_index                 = '0;
    cfg_data                  = '0;
    tick_req_bus.valid        = 1'b0;
    tick_req_bus.byte_offered = 1'b0;
    tick_req_bus.byte_value   = '0;
    tick_req_bus.byte_is_last = 1'b0;
    line_bus.ready            = 1'b0;
    reset_model();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // frame start on reset timing: first low half and into the high half
    repeat (3) push_tick(1'b0, 8'hFF, 1'b1);
    push_tick(1'b1, 8'hA5, 1'b0);
    repeat (205) push_tick(1'b0, 8'hFF, 1'b0);
    wait_drained();

    // shortest timing: finish that frame, hand-placed frame, then streaming bytes
    set_timing(12'd1, 12'd1, 12'd1, 12'd1, 12'd1, 12'd1);
    finish_frame();
    push_tick(1'b0, 8'hFF, 1'b1);
    push_tick(1'b1, 8'h00, 1'b1);     // starts preamble, not taken
    push_tick(1'b1, 8'hFF, 1'b0);     // ignored in preamble
    push_tick(1'b1, 8'hFF, 1'b1);     // ignored in tail
    push_tick(1'b0, 8'h3C, 1'b1);     // slot waits
    push_tick(1'b0, 8'hC3, 1'b0);
    push_tick(1'b1, 8'h00, 1'b0);     // all-zero byte
    repeat (15) push_tick(1'b1, 8'h55, 1'b1);  // ignored during bits
    push_tick(1'b1, 8'hFF, 1'b1);     // all-ones last byte
    finish_frame();
    run_random(70, 100);

    // zero lengths act as one; spare index must do nothing
    set_timing(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
    write_reg(REG_SPARE, 12'hFFF);
    run_random(70, 60);

    repeat (2) begin
      set_timing(12'($urandom_range(1, 3)), 12'($urandom_range(1, 3)),
                 12'($urandom_range(1, 3)), 12'($urandom_range(1, 3)),
                 12'($urandom_range(1, 3)), 12'($urandom_range(1, 3)));
      case ($urandom_range(0, 3))
        0:       dens = 100;
        1:       dens = 85;
        2:       dens = 50;
        default: dens = 25;
      endcase
      run_random(60, dens);
    end

    // upper data bits dropped: 255 preamble periods
    set_timing(12'd2, 12'd1, 12'd1, 12'd1, 12'hFFF, 12'd2);
    run_random(20, 100);

    // longest lengths: frame start, then finished on short timing
    set_timing(12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd1, 12'd4095);
    push_tick(1'b1, 8'h5A, 1'b0);
    repeat (100) push_tick(1'b0, 8'h5A, 1'b1);
    wait_drained();
    set_timing(12'd1, 12'd2, 12'd1, 12'd1, 12'd1, 12'd1);
    finish_frame();

    wait_drained();
    repeat (16) @(posedge clk);
    if (line_ticks_due.size() != 0) begin
      errors++;
      $display("%0t: results missing, expected %0d more, got none",
               $time, line_ticks_due.size());
    end
    $display("Checked %0d ticks over %0d timing settings: %0d bytes taken, %0d frames sent.",
             ticks_seen, settings, bytes_taken, frames_done);
    if (errors == 0) begin
      $display("pulse_width_rf_frame_transmitter_top_tb: done, clean");
    end else begin
      $display("pulse_width_rf_frame_transmitter_top_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #80_000_000;
    $display("Timed out with %0d results still due.", line_ticks_due.size());
    $display("pulse_width_rf_frame_transmitter_top_tb: done, errors");
    $finish;
  end

endmodule
